// ===== sv/rfh_pkg.sv =====
package rfh_pkg;

  localparam int LEVEL_W    = 8;
  localparam int TIME_W     = 16;
  localparam int BASE_W     = 8;
  localparam int STEP_W     = 8;
  localparam int INC_W      = LEVEL_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TIME_W;

  // Serial divider: one quotient bit per cycle.
  localparam int DIVIDEND_W = TIME_W;
  localparam int DIVISOR_W  = STEP_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam logic [BASE_W-1:0] BASE_RESET       = BASE_W'(10);
  localparam logic [TIME_W-1:0] MIN_RESET        = TIME_W'(10);
  localparam logic [STEP_W-1:0] STEP_TOTAL_RESET = STEP_W'(10);
  localparam logic [STEP_W-1:0] STEP_MAX         = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIME  = 1'b1;

  // Which division the shared divider is working on.
  typedef enum logic [2:0] {
    SEL_SHORT,
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE,
    SEL_TRANS
  } rfh_sel_t;

  // How the datapath finishes the current item.
  typedef enum logic [1:0] {
    KIND_IGNORE,
    KIND_ZERO,
    KIND_LOAD,
    KIND_TICK
  } rfh_kind_t;

  typedef struct packed {
    logic      latch;
    logic      div_start;
    rfh_sel_t  div_sel;
    logic      finish;
    rfh_kind_t kind;
  } rfh_cmd_t;

  typedef struct packed {
    logic func;
    logic ignore;
    logic q_zero;
    logic div_done;
    logic out_free;
  } rfh_status_t;

endpackage

// ===== sv/rgb_fade_hold_engine.sv =====
// Channel  Handshake            Payload
// -------  -------------------  ------------------------------------------------------
// in       in_valid / in_stall  func, red, green, blue, hold_ms, transition_ms
// out      out_valid/out_stall  drive, red_level, green_level, blue_level, interval_ms,
//                               finished
// cfg      cfg_we               cfg_index, cfg_data (0 = base time, 1 = minimum time)
//
// A tick or an ignored load goes from S_CHECK to S_FINISH, which registers its result
// once the output is free. A node load first runs five divisions on the serial divider,
// which produces one quotient bit per cycle. A zero-step load stops after the first one.
// The next input is taken in the cycle after the result is written. Reset is synchronous.
// One transaction is in flight at a time; a stalled result holds the next one back
// only at its final write, and the next input is taken while a result waits.
module rgb_fade_hold_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [rfh_pkg::LEVEL_W-1:0]    red,
  input  logic [rfh_pkg::LEVEL_W-1:0]    green,
  input  logic [rfh_pkg::LEVEL_W-1:0]    blue,
  input  logic [rfh_pkg::TIME_W-1:0]     hold_ms,
  input  logic [rfh_pkg::TIME_W-1:0]     transition_ms,
  input  logic                           cfg_we,
  input  logic [rfh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfh_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           drive,
  output logic [rfh_pkg::LEVEL_W-1:0]    red_level,
  output logic [rfh_pkg::LEVEL_W-1:0]    green_level,
  output logic [rfh_pkg::LEVEL_W-1:0]    blue_level,
  output logic [rfh_pkg::TIME_W-1:0]     interval_ms,
  output logic                           finished
);
  import rfh_pkg::*;

  rfh_cmd_t    cmd;
  rfh_status_t status;

  rfh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rfh_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .func          (func),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .hold_ms       (hold_ms),
    .transition_ms (transition_ms),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive         (drive),
    .red_level     (red_level),
    .green_level   (green_level),
    .blue_level    (blue_level),
    .interval_ms   (interval_ms),
    .finished      (finished)
  );

endmodule

// ===== sv/rfh_div.sv =====
module rfh_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rfh_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [rfh_pkg::DIVISOR_W-1:0]  divisor,
  output logic [rfh_pkg::DIVIDEND_W-1:0] quotient,
  output logic                           done
);
  import rfh_pkg::*;

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // Restoring division. A zero divisor always fits, giving an all-ones quotient.
  assign shifted = {rem, quo[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '1;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

// ===== sv/rfh_datapath.sv =====
module rfh_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  rfh_pkg::rfh_cmd_t              cmd,
  output rfh_pkg::rfh_status_t           status,
  input  logic                           func,
  input  logic [rfh_pkg::LEVEL_W-1:0]    red,
  input  logic [rfh_pkg::LEVEL_W-1:0]    green,
  input  logic [rfh_pkg::LEVEL_W-1:0]    blue,
  input  logic [rfh_pkg::TIME_W-1:0]     hold_ms,
  input  logic [rfh_pkg::TIME_W-1:0]     transition_ms,
  input  logic                           cfg_we,
  input  logic [rfh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfh_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           drive,
  output logic [rfh_pkg::LEVEL_W-1:0]    red_level,
  output logic [rfh_pkg::LEVEL_W-1:0]    green_level,
  output logic [rfh_pkg::LEVEL_W-1:0]    blue_level,
  output logic [rfh_pkg::TIME_W-1:0]     interval_ms,
  output logic                           finished
);
  import rfh_pkg::*;

  // Configuration
  logic [BASE_W-1:0] base_time;
  logic [TIME_W-1:0] min_time;

  // Latched input transaction
  logic              in_func;
  logic [LEVEL_W-1:0] in_red, in_green, in_blue;
  logic [TIME_W-1:0] in_hold, in_trans;

  // Engine state
  logic [LEVEL_W-1:0] cur_red, cur_green, cur_blue;
  logic [TIME_W-1:0]  cur_transition;
  logic [LEVEL_W-1:0] tgt_red, tgt_green, tgt_blue;
  logic [TIME_W-1:0]  tgt_transition;
  logic [STEP_W-1:0]  step_total, step_index;
  logic [INC_W-1:0]   red_inc, green_inc, blue_inc;
  logic [TIME_W-1:0]  step_interval, hold_left;
  logic               done_flag;

  // Division results of the load in progress
  logic [STEP_W-1:0]  q;
  logic [INC_W-1:0]   new_red_inc, new_green_inc, new_blue_inc;
  logic [TIME_W-1:0]  new_interval;

  // Divider
  logic [DIVIDEND_W-1:0] div_dividend, div_quotient;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_done;
  logic [TIME_W-1:0]     shorter_min, shorter;
  logic                  red_neg, green_neg, blue_neg;
  logic [LEVEL_W-1:0]    red_mag, green_mag, blue_mag;
  logic [INC_W-1:0]      inc_mag;
  logic [STEP_W-1:0]     q_sat;

  // Next values
  logic [LEVEL_W-1:0] cur_red_next, cur_green_next, cur_blue_next;
  logic [TIME_W-1:0]  cur_transition_next;
  logic [LEVEL_W-1:0] tgt_red_next, tgt_green_next, tgt_blue_next;
  logic [TIME_W-1:0]  tgt_transition_next;
  logic [STEP_W-1:0]  step_total_next, step_index_next;
  logic [INC_W-1:0]   red_inc_next, green_inc_next, blue_inc_next;
  logic [TIME_W-1:0]  step_interval_next, hold_left_next;
  logic               done_flag_next;
  logic               drive_next;
  logic [LEVEL_W-1:0] red_level_next, green_level_next, blue_level_next;
  logic [TIME_W-1:0]  interval_next;
  logic [STEP_W-1:0]  idx_inc;
  logic [2*LEVEL_W-1:0] red_prod, green_prod, blue_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_time <= BASE_RESET;
      min_time  <= MIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_TIME: base_time <= cfg_data[BASE_W-1:0];
        CFG_MIN_TIME:  min_time  <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_func  <= func;
      in_red   <= red;
      in_green <= green;
      in_blue  <= blue;
      in_hold  <= hold_ms;
      in_trans <= transition_ms;
    end
  end

  // Operand selection for the shared divider
  assign shorter_min = (in_hold < in_trans) ? in_hold : in_trans;
  assign shorter     = (shorter_min < min_time) ? min_time : shorter_min;
  assign red_neg     = in_red < cur_red;
  assign green_neg   = in_green < cur_green;
  assign blue_neg    = in_blue < cur_blue;
  assign red_mag     = red_neg ? cur_red - in_red : in_red - cur_red;
  assign green_mag   = green_neg ? cur_green - in_green : in_green - cur_green;
  assign blue_mag    = blue_neg ? cur_blue - in_blue : in_blue - cur_blue;

  always_comb begin
    div_divisor  = q;
    div_dividend = in_trans;
    unique case (cmd.div_sel)
      SEL_SHORT: begin
        div_dividend = shorter;
        div_divisor  = base_time;
      end
      SEL_RED:   div_dividend = DIVIDEND_W'(red_mag);
      SEL_GREEN: div_dividend = DIVIDEND_W'(green_mag);
      SEL_BLUE:  div_dividend = DIVIDEND_W'(blue_mag);
      SEL_TRANS: div_dividend = in_trans;
      default:   div_dividend = in_trans;
    endcase
  end

  rfh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  assign q_sat   = (|div_quotient[DIVIDEND_W-1:STEP_W]) ? STEP_MAX
                                                          : div_quotient[STEP_W-1:0];
  assign inc_mag = {1'b0, div_quotient[LEVEL_W-1:0]};

  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (cmd.div_sel)
        SEL_SHORT: q <= q_sat;
        SEL_RED:   new_red_inc   <= red_neg ? -inc_mag : inc_mag;
        SEL_GREEN: new_green_inc <= green_neg ? -inc_mag : inc_mag;
        SEL_BLUE:  new_blue_inc  <= blue_neg ? -inc_mag : inc_mag;
        SEL_TRANS: new_interval  <= div_quotient;
        default:   ;
      endcase
    end
  end

  // Ramp level: only the low eight bits of base + index * increment survive.
  assign idx_inc    = step_index + 1'b1;
  assign red_prod   = idx_inc * red_inc[LEVEL_W-1:0];
  assign green_prod = idx_inc * green_inc[LEVEL_W-1:0];
  assign blue_prod  = idx_inc * blue_inc[LEVEL_W-1:0];

  always_comb begin
    cur_red_next        = cur_red;
    cur_green_next      = cur_green;
    cur_blue_next       = cur_blue;
    cur_transition_next = cur_transition;
    tgt_red_next        = tgt_red;
    tgt_green_next      = tgt_green;
    tgt_blue_next       = tgt_blue;
    tgt_transition_next = tgt_transition;
    step_total_next     = step_total;
    step_index_next     = step_index;
    red_inc_next        = red_inc;
    green_inc_next      = green_inc;
    blue_inc_next       = blue_inc;
    step_interval_next  = step_interval;
    hold_left_next      = hold_left;
    done_flag_next      = done_flag;
    drive_next          = 1'b0;
    red_level_next      = '0;
    green_level_next    = '0;
    blue_level_next     = '0;
    interval_next       = '0;
    unique case (cmd.kind)
      KIND_IGNORE: ;
      KIND_ZERO: begin
        tgt_red_next        = in_red;
        tgt_green_next      = in_green;
        tgt_blue_next       = in_blue;
        tgt_transition_next = in_trans;
        step_total_next     = q;
      end
      KIND_LOAD: begin
        tgt_red_next        = in_red;
        tgt_green_next      = in_green;
        tgt_blue_next       = in_blue;
        tgt_transition_next = in_trans;
        step_total_next     = q;
        red_inc_next        = new_red_inc;
        green_inc_next      = new_green_inc;
        blue_inc_next       = new_blue_inc;
        step_interval_next  = new_interval;
        hold_left_next      = in_hold;
        step_index_next     = STEP_W'(1);
        done_flag_next      = 1'b0;
        drive_next          = 1'b1;
        red_level_next      = cur_red + new_red_inc[LEVEL_W-1:0];
        green_level_next    = cur_green + new_green_inc[LEVEL_W-1:0];
        blue_level_next     = cur_blue + new_blue_inc[LEVEL_W-1:0];
        interval_next       = new_interval;
      end
      KIND_TICK: begin
        priority if (step_index == '0) begin
          // Holding: count down in base-time steps until the hold runs out.
          if (hold_left >= TIME_W'(base_time)) begin
            hold_left_next   = hold_left - TIME_W'(base_time);
            drive_next       = 1'b1;
            red_level_next   = cur_red;
            green_level_next = cur_green;
            blue_level_next  = cur_blue;
            interval_next    = TIME_W'(base_time);
          end else begin
            done_flag_next = 1'b1;
          end
        end else if (step_total == '0 ||
                     ({1'b0, step_index} + 1'b1) >= {1'b0, step_total}) begin
          // Last step lands exactly on the target.
          cur_red_next        = tgt_red;
          cur_green_next      = tgt_green;
          cur_blue_next       = tgt_blue;
          cur_transition_next = tgt_transition;
          step_index_next     = '0;
          step_interval_next  = '0;
          drive_next          = 1'b1;
          red_level_next      = tgt_red;
          green_level_next    = tgt_green;
          blue_level_next     = tgt_blue;
          interval_next       = step_interval;
        end else begin
          step_index_next  = idx_inc;
          drive_next       = 1'b1;
          red_level_next   = cur_red + red_prod[LEVEL_W-1:0];
          green_level_next = cur_green + green_prod[LEVEL_W-1:0];
          blue_level_next  = cur_blue + blue_prod[LEVEL_W-1:0];
          interval_next    = step_interval;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_red        <= '0;
      cur_green      <= '0;
      cur_blue       <= '0;
      cur_transition <= '0;
      tgt_red        <= '0;
      tgt_green      <= '0;
      tgt_blue       <= '0;
      tgt_transition <= '0;
      step_total     <= STEP_TOTAL_RESET;
      step_index     <= '0;
      red_inc        <= '0;
      green_inc      <= '0;
      blue_inc       <= '0;
      step_interval  <= '0;
      hold_left      <= '0;
      done_flag      <= 1'b1;
    end else if (cmd.finish) begin
      cur_red        <= cur_red_next;
      cur_green      <= cur_green_next;
      cur_blue       <= cur_blue_next;
      cur_transition <= cur_transition_next;
      tgt_red        <= tgt_red_next;
      tgt_green      <= tgt_green_next;
      tgt_blue       <= tgt_blue_next;
      tgt_transition <= tgt_transition_next;
      step_total     <= step_total_next;
      step_index     <= step_index_next;
      red_inc        <= red_inc_next;
      green_inc      <= green_inc_next;
      blue_inc       <= blue_inc_next;
      step_interval  <= step_interval_next;
      hold_left      <= hold_left_next;
      done_flag      <= done_flag_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      drive       <= drive_next;
      red_level   <= red_level_next;
      green_level <= green_level_next;
      blue_level  <= blue_level_next;
      interval_ms <= interval_next;
      finished    <= done_flag_next;
    end
  end

  assign status.func     = in_func;
  assign status.ignore   = ((in_red | in_green | in_blue) == '0 &&
                            (in_hold | in_trans) == '0) ||
                           (in_red == cur_red && in_green == cur_green &&
                            in_blue == cur_blue && in_trans == cur_transition);
  assign status.q_zero   = (q == '0);
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || !out_stall;

endmodule

// ===== sv/rfh_ctrl.sv =====
module rfh_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rfh_pkg::rfh_status_t status,
  output rfh_pkg::rfh_cmd_t    cmd
);
  import rfh_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_CHECK     = 5'b00010,
    S_DIV_START = 5'b00100,
    S_DIV_WAIT  = 5'b01000,
    S_FINISH    = 5'b10000
  } rfh_state_t;

  rfh_state_t state, state_next;
  rfh_sel_t   sel, sel_next;
  rfh_kind_t  kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= SEL_SHORT;
      kind  <= KIND_IGNORE;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next    = state;
    sel_next      = sel;
    kind_next     = kind;
    cmd.latch     = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = sel;
    cmd.finish    = 1'b0;
    cmd.kind      = kind;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (status.func) begin
          kind_next  = KIND_TICK;
          state_next = S_FINISH;
        end else if (status.ignore) begin
          kind_next  = KIND_IGNORE;
          state_next = S_FINISH;
        end else begin
          sel_next   = SEL_SHORT;
          state_next = S_DIV_START;
        end
      end
      S_DIV_START: begin
        // A zero step count stops the load before the increments are worked out.
        if (sel == SEL_RED && status.q_zero) begin
          kind_next  = KIND_ZERO;
          state_next = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          unique case (sel)
            SEL_SHORT: begin
              sel_next   = SEL_RED;
              state_next = S_DIV_START;
            end
            SEL_RED: begin
              sel_next   = SEL_GREEN;
              state_next = S_DIV_START;
            end
            SEL_GREEN: begin
              sel_next   = SEL_BLUE;
              state_next = S_DIV_START;
            end
            SEL_BLUE: begin
              sel_next   = SEL_TRANS;
              state_next = S_DIV_START;
            end
            SEL_TRANS: begin
              kind_next  = KIND_LOAD;
              state_next = S_FINISH;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

// ===== bench/rgb_fade_hold_engine_tb.sv =====
`timescale 1ns / 1ps

module rgb_fade_hold_engine_tb;
  import rfh_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic               func;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [TIME_W-1:0]  hold_ms;
    logic [TIME_W-1:0]  transition_ms;
  } node_t;

  typedef struct packed {
    logic               drive;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [TIME_W-1:0]  interval;
    logic               finished;
  } led_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  func = 1'b0;
  logic [LEVEL_W-1:0]    red = '0;
  logic [LEVEL_W-1:0]    green = '0;
  logic [LEVEL_W-1:0]    blue = '0;
  logic [TIME_W-1:0]     hold_ms = '0;
  logic [TIME_W-1:0]     transition_ms = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  drive;
  logic [LEVEL_W-1:0]    red_level;
  logic [LEVEL_W-1:0]    green_level;
  logic [LEVEL_W-1:0]    blue_level;
  logic [TIME_W-1:0]     interval_ms;
  logic                  finished;

  rgb_fade_hold_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .red(red), .green(green), .blue(blue),
    .hold_ms(hold_ms), .transition_ms(transition_ms),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .drive(drive), .red_level(red_level), .green_level(green_level),
    .blue_level(blue_level), .interval_ms(interval_ms), .finished(finished)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  node_t    node_queue[$];
  led_out_t led_expected[$];
  node_t    last_load = '0;
  int       pushed = 0;
  int       err_count = 0;
  int       in_gap = 0;
  int       out_gap = 0;
  int       quiet = 0;
  logic     in_took = 1'b0;
  logic     idle_on = 1'b1;
  logic     drain_wait = 1'b0;

  // Private copy of the fade engine's registers and state.
  logic [BASE_W-1:0]        base_cfg = BASE_RESET;
  logic [TIME_W-1:0]        min_cfg = MIN_RESET;
  logic [LEVEL_W-1:0]       cur_r = '0, cur_g = '0, cur_b = '0;
  logic [LEVEL_W-1:0]       tgt_r = '0, tgt_g = '0, tgt_b = '0;
  logic [TIME_W-1:0]        cur_trans = '0, tgt_trans = '0;
  logic [TIME_W-1:0]        step_iv = '0, hold_left = '0;
  logic [STEP_W-1:0]        step_total = STEP_TOTAL_RESET, step_idx = '0;
  logic signed [INC_W-1:0]  inc_r = '0, inc_g = '0, inc_b = '0;
  logic                     done_flag = 1'b1;

  function automatic logic [LEVEL_W-1:0] level_at(input logic [LEVEL_W-1:0] start,
                                                  input logic signed [INC_W-1:0] inc,
                                                  input logic [STEP_W-1:0] k);
    int v;
    v = int'(start) + int'(k) * int'(inc);
    return v[LEVEL_W-1:0];
  endfunction

  function automatic led_out_t predict_led(input node_t n);
    led_out_t res;
    int       shorter;
    int       q;
    res = '0;
    if (!n.func) begin
      if ({n.red, n.green, n.blue, n.hold_ms, n.transition_ms} != '0 &&
          !(n.red == cur_r && n.green == cur_g && n.blue == cur_b &&
            n.transition_ms == cur_trans)) begin
        tgt_r = n.red;
        tgt_g = n.green;
        tgt_b = n.blue;
        tgt_trans = n.transition_ms;
        shorter = (n.hold_ms < n.transition_ms) ? int'(n.hold_ms) : int'(n.transition_ms);
        if (shorter < int'(min_cfg)) shorter = int'(min_cfg);
        // A zero base time gives an all-ones quotient, saturated to 255 steps.
        q = (base_cfg == '0) ? 255 : shorter / int'(base_cfg);
        if (q > 255) q = 255;
        step_total = STEP_W'(q);
        if (q != 0) begin
          inc_r = INC_W'((int'(n.red) - int'(cur_r)) / q);
          inc_g = INC_W'((int'(n.green) - int'(cur_g)) / q);
          inc_b = INC_W'((int'(n.blue) - int'(cur_b)) / q);
          step_iv = TIME_W'(int'(n.transition_ms) / q);
          hold_left = n.hold_ms;
          step_idx = STEP_W'(1);
          done_flag = 1'b0;
          res.drive = 1'b1;
          res.red = level_at(cur_r, inc_r, step_idx);
          res.green = level_at(cur_g, inc_g, step_idx);
          res.blue = level_at(cur_b, inc_b, step_idx);
          res.interval = step_iv;
        end
      end
    end else if (step_idx == '0) begin
      if (hold_left >= TIME_W'(base_cfg)) begin
        hold_left = hold_left - TIME_W'(base_cfg);
        res.drive = 1'b1;
        res.red = cur_r;
        res.green = cur_g;
        res.blue = cur_b;
        res.interval = TIME_W'(base_cfg);
      end else begin
        done_flag = 1'b1;
      end
    end else if (step_total == '0 || int'(step_idx) + 1 >= int'(step_total)) begin
      res.drive = 1'b1;
      res.red = tgt_r;
      res.green = tgt_g;
      res.blue = tgt_b;
      res.interval = step_iv;
      cur_r = tgt_r;
      cur_g = tgt_g;
      cur_b = tgt_b;
      cur_trans = tgt_trans;
      step_idx = '0;
      step_iv = '0;
    end else begin
      step_idx = step_idx + 1'b1;
      res.drive = 1'b1;
      res.red = level_at(cur_r, inc_r, step_idx);
      res.green = level_at(cur_g, inc_g, step_idx);
      res.blue = level_at(cur_b, inc_b, step_idx);
      res.interval = step_iv;
    end
    res.finished = done_flag;
    return res;
  endfunction

  function automatic node_t mk_node(input logic f, input int r, input int g, input int b,
                                    input int h, input int t);
    node_t n;
    n.func = f;
    n.red = LEVEL_W'(r);
    n.green = LEVEL_W'(g);
    n.blue = LEVEL_W'(b);
    n.hold_ms = TIME_W'(h);
    n.transition_ms = TIME_W'(t);
    return n;
  endfunction

  function automatic node_t rand_node(input logic f);
    return mk_node(f, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic push_node(input node_t n);
    node_queue.push_back(n);
    pushed++;
  endtask

  // One node load followed by a run of ticks, usually long enough to finish the
  // fade and the hold so that the finished flag is reached.
  task automatic add_run();
    node_t n;
    int    unit;
    int    shorter;
    int    steps;
    int    need;
    int    ticks;
    unit = (base_cfg == '0) ? 1 : int'(base_cfg);
    n = rand_node(1'b0);
    case ($urandom_range(0, 11))
      0: n = '0;
      1: begin
        n = last_load;
        n.hold_ms = TIME_W'($urandom);
      end
      2: ;
      default: begin
        n.transition_ms = TIME_W'(unit * $urandom_range(0, 10) + $urandom_range(0, unit - 1));
        n.hold_ms = TIME_W'(unit * $urandom_range(0, 12) + $urandom_range(0, unit - 1));
      end
    endcase
    if (n != '0) last_load = n;
    shorter = (n.hold_ms < n.transition_ms) ? int'(n.hold_ms) : int'(n.transition_ms);
    if (shorter < int'(min_cfg)) shorter = int'(min_cfg);
    steps = (base_cfg == '0) ? 255 : shorter / unit;
    if (steps > 255) steps = 255;
    need = steps + ((base_cfg == '0) ? 5 : int'(n.hold_ms) / unit) + 1;
    if (need <= 60 && $urandom_range(0, 3) != 0) ticks = need - 1 + $urandom_range(0, 2);
    else ticks = $urandom_range(0, 40);
    push_node(n);
    repeat (ticks) push_node(rand_node(1'b1));
  endtask

  task automatic fill_random(input int count);
    int start;
    start = pushed;
    while (pushed - start < count) add_run();
  endtask

  task automatic wait_idle();
    while (node_queue.size() != 0 || in_valid || led_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BASE_TIME) base_cfg = BASE_W'(value);
    else min_cfg = TIME_W'(value);
  endtask

  task automatic set_times(input int base, input int min_time);
    wait_idle();
    write_reg(CFG_BASE_TIME, base);
    write_reg(CFG_MIN_TIME, min_time);
  endtask

  // The expectation is formed when the input transaction is taken.
  always @(posedge clk) begin : node_accept
    in_took = !rst && in_valid && !in_stall;
    if (in_took)
      led_expected.push_back(predict_led({func, red, green, blue, hold_ms, transition_ms}));
  end

  always @(negedge clk) begin : node_driver
    node_t nxt;
    if (!rst && !(in_valid && !in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (drain_wait && led_expected.size() != 0) begin
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 16);
        drain_wait = ($urandom_range(0, 15) == 0);
        in_valid <= 1'b0;
      end else if (node_queue.size() != 0) begin
        drain_wait = 1'b0;
        nxt = node_queue.pop_front();
        func <= nxt.func;
        red <= nxt.red;
        green <= nxt.green;
        blue <= nxt.blue;
        hold_ms <= nxt.hold_ms;
        transition_ms <= nxt.transition_ms;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_stall
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : led_monitor
    led_out_t got;
    led_out_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {drive, red_level, green_level, blue_level, interval_ms, finished};
      if (led_expected.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: drive=%0b rgb=%0d/%0d/%0d interval=%0d finished=%0b",
                   got.drive, got.red, got.green, got.blue, got.interval, got.finished);
      end else begin
        want = led_expected.pop_front();
        if (got.drive !== want.drive || got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.interval !== want.interval ||
            got.finished !== want.finished) begin
          err_count++;
          if (err_count <= 10)
            $display({"mismatch: expected drive=%0b rgb=%0d/%0d/%0d interval=%0d ",
                      "finished=%0b, got drive=%0b rgb=%0d/%0d/%0d interval=%0d finished=%0b"},
                     want.drive, want.red, want.green, want.blue, want.interval,
                     want.finished, got.drive, got.red, got.green, got.blue, got.interval,
                     got.finished);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("rgb_fade_hold_engine test failed");
      $finish;
    end else begin
      quiet++;
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed checks with the reset register values.
    push_node(mk_node(1'b0, 0, 0, 0, 0, 0));
    push_node(rand_node(1'b1));
    push_node(mk_node(1'b0, 255, 255, 255, 40, 100));
    repeat (8) push_node(rand_node(1'b1));
    // Same colour and transition as the node just reached, so it is ignored.
    push_node(mk_node(1'b0, 255, 255, 255, 5, 100));
    push_node(mk_node(1'b0, 0, 0, 0, 65535, 65535));
    repeat (2) push_node(rand_node(1'b1));
    push_node(mk_node(1'b0, 1, 128, 254, 0, 0));
    repeat (2) push_node(rand_node(1'b1));

    set_times(10, 10);
    drain_wait = 1'b1;
    fill_random(100);

    set_times(1, 1);
    fill_random(90);

    // A zero step count arriving mid-fade makes the next tick jump to the target.
    set_times(255, 1);
    push_node(mk_node(1'b0, 200, 100, 50, 1000, 1000));
    push_node(mk_node(1'b0, 10, 20, 30, 100, 100));
    repeat (2) push_node(rand_node(1'b1));
    fill_random(80);

    set_times(255, 65535);
    fill_random(30);

    set_times(0, 10);
    fill_random(30);

    set_times(37, 300);
    wait_idle();
    idle_on = 1'b0;
    fill_random(80);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    err_count += led_expected.size();
    if (err_count == 0) begin
      $display("rgb_fade_hold_engine test passed");
    end else begin
      $display("rgb_fade_hold_engine test failed");
    end
    $finish;
  end

endmodule

// ===== rgb_fade_hold_engine.f =====
sv/rfh_pkg.sv
sv/rfh_div.sv
sv/rfh_datapath.sv
sv/rfh_ctrl.sv
sv/rgb_fade_hold_engine.sv
bench/rgb_fade_hold_engine_tb.sv
